### src/cbbd_pkg.sv
// Shared types, constants and the luma function of the content bounds / blank detector.
package cbbd_pkg;

  // Field widths
  localparam int COORD_W    = 12;
  localparam int COUNT_W    = 25;
  localparam int LW_W       = 13;
  localparam int LEVEL_W    = 18;
  localparam int RATIO_W    = 14;
  localparam int PROD_W     = COUNT_W + RATIO_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 18;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 56;

  // Default for the image dimension limit
  localparam int MAX_DIM_DEF = 4096;
  // Coordinates are 12 bits, so a row never exceeds 4096 pixels
  localparam int COORD_LIM   = 4096;

  localparam logic [COORD_W-1:0] COORD_MAX = 12'hFFF;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 25'h1FF_FFFF;
  localparam logic [RATIO_W-1:0] RATIO_SCALE = 14'd10000;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WHITE_LEVEL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WHITE_RATIO = 2'd2;

  // Register reset values
  localparam logic [LW_W-1:0]    LINE_WIDTH_RST  = 13'd4096;
  localparam logic [LEVEL_W-1:0] WHITE_LEVEL_RST = 18'd252000;
  localparam logic [RATIO_W-1:0] WHITE_RATIO_RST = 14'd9995;

  // Per-image summary handed from the accumulator to the ratio stage
  typedef struct packed {
    logic               found;
    logic [COORD_W-1:0] left;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] right;
    logic [COORD_W-1:0] bottom;
    logic [COUNT_W-1:0] white_count;
    logic [COUNT_W-1:0] pixel_count;
  } result_t;

  // Luma scaled by 1000: 114*B + 587*G + 299*R, at most 255000
  function automatic logic [LEVEL_W-1:0] luma(input logic [23:0] px);
    logic [LEVEL_W-1:0] b;
    logic [LEVEL_W-1:0] g;
    logic [LEVEL_W-1:0] r;
    b = {10'b0, px[7:0]};
    g = {10'b0, px[15:8]};
    r = {10'b0, px[23:16]};
    return (b * 18'd114) + (g * 18'd587) + (r * 18'd299);
  endfunction

endpackage

### src/cbbd_accum.sv
// Per-pixel classification and bounding box / count accumulation, one pixel per clock while s_tready is high.
module cbbd_accum #(
  parameter int MAX_DIM = cbbd_pkg::MAX_DIM_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [cbbd_pkg::IN_DATA_W-1:0] s_tdata,
  input  logic                          s_tlast,
  input  logic [cbbd_pkg::LW_W-1:0]     line_width,
  input  logic [cbbd_pkg::LEVEL_W-1:0]  white_level,
  output logic                          res_valid,
  output cbbd_pkg::result_t             res,
  input  logic                          res_ready
);
  import cbbd_pkg::*;

  localparam int WLIM = (MAX_DIM < COORD_LIM) ? MAX_DIM : COORD_LIM;
  localparam logic [LW_W-1:0] WLIM_V = LW_W'(WLIM);

  // Image state
  logic [COORD_W-1:0] column;
  logic [COORD_W-1:0] row;
  logic [COORD_W-1:0] min_col;
  logic [COORD_W-1:0] min_row;
  logic [COORD_W-1:0] max_col;
  logic [COORD_W-1:0] max_row;
  logic               found;
  logic [COUNT_W-1:0] white_count;
  logic [COUNT_W-1:0] pixel_count;

  logic               accept;
  logic [LW_W-1:0]    width;
  logic               wrap_pre;
  logic               wrap_post;
  logic [COORD_W-1:0] col;
  logic [COORD_W-1:0] row_a;
  logic [COORD_W:0]   col_inc;
  logic               content;
  logic [COORD_W-1:0] column_next;
  logic [COORD_W-1:0] row_next;
  logic [COORD_W-1:0] min_col_next;
  logic [COORD_W-1:0] min_row_next;
  logic [COORD_W-1:0] max_col_next;
  logic [COORD_W-1:0] max_row_next;
  logic               found_next;
  logic [COUNT_W-1:0] white_count_next;
  logic [COUNT_W-1:0] pixel_count_next;

  assign s_tready = !res_valid || res_ready;
  assign accept   = s_tvalid && s_tready;

  // Effective row length: zero acts as one, clamp to the dimension limit
  always_comb begin
    width = line_width;
    if (width == '0) begin
      width = LW_W'(1);
    end
    if (width > WLIM_V) begin
      width = WLIM_V;
    end
  end

  // Position of this pixel, with a wrap if the width shrank under the column
  always_comb begin
    wrap_pre  = {1'b0, column} >= width;
    col       = wrap_pre ? '0 : column;
    row_a     = (wrap_pre && row < COORD_MAX) ? row + 1'b1 : row;
    col_inc   = {1'b0, col} + 1'b1;
    wrap_post = col_inc >= width;
    column_next = wrap_post ? '0 : col_inc[COORD_W-1:0];
    row_next    = (wrap_post && row_a < COORD_MAX) ? row_a + 1'b1 : row_a;
  end

  // Classification and running bounds / counts
  always_comb begin
    content          = luma(s_tdata[23:0]) < white_level;
    min_col_next     = min_col;
    min_row_next     = min_row;
    max_col_next     = max_col;
    max_row_next     = max_row;
    found_next       = found;
    white_count_next = white_count;
    pixel_count_next = (pixel_count < COUNT_MAX) ? pixel_count + 1'b1 : pixel_count;
    if (content) begin
      if (col < min_col) begin
        min_col_next = col;
      end
      if (row_a < min_row) begin
        min_row_next = row_a;
      end
      if (col > max_col) begin
        max_col_next = col;
      end
      if (row_a > max_row) begin
        max_row_next = row_a;
      end
      found_next = 1'b1;
    end else if (white_count < COUNT_MAX) begin
      white_count_next = white_count + 1'b1;
    end
  end

  // State update; the last pixel of an image clears it for the next one
  always_ff @(posedge clk) begin
    if (rst) begin
      column      <= '0;
      row         <= '0;
      min_col     <= COORD_MAX;
      min_row     <= COORD_MAX;
      max_col     <= '0;
      max_row     <= '0;
      found       <= 1'b0;
      white_count <= '0;
      pixel_count <= '0;
    end else if (accept) begin
      if (s_tlast) begin
        column      <= '0;
        row         <= '0;
        min_col     <= COORD_MAX;
        min_row     <= COORD_MAX;
        max_col     <= '0;
        max_row     <= '0;
        found       <= 1'b0;
        white_count <= '0;
        pixel_count <= '0;
      end else begin
        column      <= column_next;
        row         <= row_next;
        min_col     <= min_col_next;
        min_row     <= min_row_next;
        max_col     <= max_col_next;
        max_row     <= max_row_next;
        found       <= found_next;
        white_count <= white_count_next;
        pixel_count <= pixel_count_next;
      end
    end
  end

  // Summary register, loaded on the last pixel's transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept && s_tlast) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && s_tlast) begin
      res.found       <= found_next;
      res.left        <= found_next ? min_col_next : '0;
      res.top         <= found_next ? min_row_next : '0;
      res.right       <= found_next ? max_col_next : '0;
      res.bottom      <= found_next ? max_row_next : '0;
      res.white_count <= white_count_next;
      res.pixel_count <= pixel_count_next;
    end
  end

endmodule

### src/cbbd_ratio.sv
// White-ratio test: product stage, then the compare into the output register.
module cbbd_ratio (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [cbbd_pkg::RATIO_W-1:0]   white_ratio,
  input  logic                           res_valid,
  input  cbbd_pkg::result_t              res,
  output logic                           res_ready,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [cbbd_pkg::OUT_DATA_W-1:0] m_tdata
);
  import cbbd_pkg::*;

  // Product stage
  logic               prod_valid;
  logic [PROD_W-1:0]  lhs;
  logic [PROD_W-1:0]  rhs;
  logic               found;
  logic [COORD_W-1:0] left;
  logic [COORD_W-1:0] top;
  logic [COORD_W-1:0] right;
  logic [COORD_W-1:0] bottom;

  logic out_adv;

  assign out_adv   = !m_tvalid || m_tready;
  assign res_ready = !prod_valid || out_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
    end else if (res_ready) begin
      prod_valid <= res_valid;
    end
  end

  // white_count * 10000 and white_ratio * pixel_count
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      lhs    <= {{RATIO_W{1'b0}}, res.white_count} * {{COUNT_W{1'b0}}, RATIO_SCALE};
      rhs    <= {{COUNT_W{1'b0}}, white_ratio} * {{RATIO_W{1'b0}}, res.pixel_count};
      found  <= res.found;
      left   <= res.left;
      top    <= res.top;
      right  <= res.right;
      bottom <= res.bottom;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_adv) begin
      m_tvalid <= prod_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (prod_valid && out_adv) begin
      m_tdata <= {6'b0, (lhs >= rhs), bottom, right, top, left, found};
    end
  end

endmodule

### src/content_bounds_blank_detect_unit.sv
// Top level of the content bounds / blank page detector.
//
// Input stream (s_*): one xRGB pixel per transfer in raster order, blue in
// s_tdata[7:0], green in [15:8], red in [23:16]; s_tlast marks the final
// pixel of an image. Pixels are taken at one per clock while s_tready is high.
// Output stream (m_*): one transfer per image, carrying content_found, the
// bounding box of pixels darker than white_level and the too_white flag.
// A result reaches m_tvalid after the last pixel's transfer through the pixel
// accumulator's summary register, the register of the two ratio products
// (25 x 14 bits each) and the output register, which takes the compare.
// Results can leave at one per clock while m_tready is high, so single-pixel
// images also run at full rate.
// Configuration (cfg_*): line_width, white_level and white_ratio, written
// with cfg_wen; write only while no image is in flight.
// Reset clears the image state and the pipeline and restores the register
// defaults (4096, 252000, 9995); s_tready is high right after reset.
// When the receiver stalls, results queue in the summary, product and output
// registers; s_tready drops only when all three are holding a result.
module content_bounds_blank_detect_unit #(
  parameter int MAX_DIM = cbbd_pkg::MAX_DIM_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // pixel [31:0]
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [cbbd_pkg::IN_DATA_W-1:0]  s_tdata,
  input  logic                            s_tlast,
  // content_found [0], box_left [12:1], box_top [24:13], box_right [36:25],
  // box_bottom [48:37], too_white [49], zero fill [55:50]
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [cbbd_pkg::OUT_DATA_W-1:0] m_tdata,
  input  logic                            cfg_wen,
  input  logic [cbbd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cbbd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import cbbd_pkg::*;

  logic [LW_W-1:0]    line_width;
  logic [LEVEL_W-1:0] white_level;
  logic [RATIO_W-1:0] white_ratio;

  logic    res_valid;
  logic    res_ready;
  result_t res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      line_width  <= LINE_WIDTH_RST;
      white_level <= WHITE_LEVEL_RST;
      white_ratio <= WHITE_RATIO_RST;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_LINE_WIDTH:  line_width  <= cfg_wdata[LW_W-1:0];
        REG_WHITE_LEVEL: white_level <= cfg_wdata[LEVEL_W-1:0];
        REG_WHITE_RATIO: white_ratio <= cfg_wdata[RATIO_W-1:0];
        default: ;
      endcase
    end
  end

  cbbd_accum #(
    .MAX_DIM (MAX_DIM)
  ) u_accum (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tlast     (s_tlast),
    .line_width  (line_width),
    .white_level (white_level),
    .res_valid   (res_valid),
    .res         (res),
    .res_ready   (res_ready)
  );

  cbbd_ratio u_ratio (
    .clk         (clk),
    .rst         (rst),
    .white_ratio (white_ratio),
    .res_valid   (res_valid),
    .res         (res),
    .res_ready   (res_ready),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata)
  );

endmodule

### src/cbbd_check.sv
// Port-level checks of the detector, bound to the top level.
module cbbd_check (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [55:0] m_tdata
);

  // No result is pending right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("m_tvalid high after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output changed while stalled");

  // With the output register empty the pipeline has room for a pixel
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

  // No content means an all-zero box
  a_empty_box: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[48:1] == 48'd0)
    else $error("nonzero box without content");

  // A found box is ordered
  a_box_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] |-> (m_tdata[12:1] <= m_tdata[36:25]) &&
                               (m_tdata[24:13] <= m_tdata[48:37]))
    else $error("bounding box corners out of order");

endmodule

bind content_bounds_blank_detect_unit cbbd_check u_cbbd_check (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

### dv/cbbd_checker.sv
// Scoreboard for the content bounds / blank detector: predicts each image summary and compares.
module cbbd_checker
  import cbbd_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic                  s_tlast,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  cfg_wen,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output int                    pending,
  output int                    fail_count,
  output int                    checked
);
  timeunit 1ns;
  timeprecision 1ps;

  // Result layout, lowest bit first: found, left, top, right, bottom, too_white
  typedef struct packed {
    logic               too_white;
    logic [COORD_W-1:0] bottom;
    logic [COORD_W-1:0] right;
    logic [COORD_W-1:0] top;
    logic [COORD_W-1:0] left;
    logic               found;
  } box_t;

  localparam int BOX_W = $bits(box_t);

  // Register copies
  logic [LW_W-1:0]    line_width;
  logic [LEVEL_W-1:0] white_level;
  logic [RATIO_W-1:0] white_ratio;

  // Per-image tracking
  logic [COORD_W-1:0] col_pos;
  logic [COORD_W-1:0] row_pos;
  logic [COORD_W-1:0] lo_col;
  logic [COORD_W-1:0] lo_row;
  logic [COORD_W-1:0] hi_col;
  logic [COORD_W-1:0] hi_row;
  logic               any_dark;
  logic [COUNT_W-1:0] white_seen;
  logic [COUNT_W-1:0] pixels_seen;

  // Image summaries still owed by the block, oldest first
  box_t expected_boxes[$];

  initial begin
    pending    = 0;
    fail_count = 0;
    checked    = 0;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (fail_count < 40)
      $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    fail_count++;
  endtask

  function automatic void clear_image();
    col_pos     = '0;
    row_pos     = '0;
    lo_col      = COORD_MAX;
    lo_row      = COORD_MAX;
    hi_col      = '0;
    hi_row      = '0;
    any_dark    = 1'b0;
    white_seen  = '0;
    pixels_seen = '0;
  endfunction

  // Advance the image state by one pixel; queue a summary on the last one
  function automatic void track_pixel(input logic [IN_DATA_W-1:0] px, input logic end_img);
    logic [LW_W-1:0]    w;
    logic [COORD_W-1:0] c;
    logic [31:0]        y;
    logic [63:0]        lhs;
    logic [63:0]        rhs;
    box_t               b;
    y = 32'd114 * px[7:0] + 32'd587 * px[15:8] + 32'd299 * px[23:16];
    w = (line_width == '0) ? LW_W'(1) : line_width;
    if (int'(w) > MAX_DIM) w = LW_W'(MAX_DIM);
    if (int'(w) > COORD_LIM) w = LW_W'(COORD_LIM);
    c = col_pos;
    // row got narrower than the current column: wrap now
    if ({1'b0, c} >= w) begin
      c = '0;
      if (row_pos != COORD_MAX) row_pos++;
    end
    if (pixels_seen != COUNT_MAX) pixels_seen++;
    if (y < 32'(white_level)) begin
      if (c < lo_col) lo_col = c;
      if (row_pos < lo_row) lo_row = row_pos;
      if (c > hi_col) hi_col = c;
      if (row_pos > hi_row) hi_row = row_pos;
      any_dark = 1'b1;
    end else if (white_seen != COUNT_MAX) begin
      white_seen++;
    end
    if ({1'b0, c} + 13'd1 >= w) begin
      col_pos = '0;
      if (row_pos != COORD_MAX) row_pos++;
    end else begin
      col_pos = c + 12'd1;
    end
    if (end_img) begin
      lhs         = 64'(white_seen) * 64'(RATIO_SCALE);
      rhs         = 64'(white_ratio) * 64'(pixels_seen);
      b.found     = any_dark;
      b.left      = any_dark ? lo_col : '0;
      b.top       = any_dark ? lo_row : '0;
      b.right     = any_dark ? hi_col : '0;
      b.bottom    = any_dark ? hi_row : '0;
      b.too_white = (lhs >= rhs);
      expected_boxes.push_back(b);
      clear_image();
    end
  endfunction

  // Watch config writes and both streams at every edge
  always @(posedge clk) begin : watch
    box_t got;
    box_t want;
    if (rst) begin
      line_width  = LINE_WIDTH_RST;
      white_level = WHITE_LEVEL_RST;
      white_ratio = WHITE_RATIO_RST;
      clear_image();
      expected_boxes.delete();
    end else begin
      if (cfg_wen) begin
        case (cfg_index)
          REG_LINE_WIDTH:  line_width  = cfg_wdata[LW_W-1:0];
          REG_WHITE_LEVEL: white_level = cfg_wdata[LEVEL_W-1:0];
          REG_WHITE_RATIO: white_ratio = cfg_wdata[RATIO_W-1:0];
          default: ;
        endcase
      end
      // result transfer
      if (m_tvalid && m_tready) begin
        got = box_t'(m_tdata[BOX_W-1:0]);
        if (m_tdata[OUT_DATA_W-1:BOX_W] !== '0)
          report_mismatch("zero fill", 32'(m_tdata[OUT_DATA_W-1:BOX_W]), 32'd0);
        if (expected_boxes.size() == 0) begin
          report_mismatch("result with no image pending", 32'(got.found), 32'd0);
        end else begin
          want = expected_boxes.pop_front();
          checked++;
          if (got.found !== want.found)
            report_mismatch("content_found", 32'(got.found), 32'(want.found));
          if (got.left !== want.left)
            report_mismatch("box_left", 32'(got.left), 32'(want.left));
          if (got.top !== want.top)
            report_mismatch("box_top", 32'(got.top), 32'(want.top));
          if (got.right !== want.right)
            report_mismatch("box_right", 32'(got.right), 32'(want.right));
          if (got.bottom !== want.bottom)
            report_mismatch("box_bottom", 32'(got.bottom), 32'(want.bottom));
          if (got.too_white !== want.too_white)
            report_mismatch("too_white", 32'(got.too_white), 32'(want.too_white));
        end
      end
      // pixel transfer
      if (s_tvalid && s_tready) track_pixel(s_tdata, s_tlast);
    end
    pending <= expected_boxes.size();
  end

endmodule

### dv/tb_content_bounds_blank_detect_unit.sv
// Stimulus and verdict for the content bounds / blank detector, checked by cbbd_checker.
module tb_content_bounds_blank_detect_unit;
  import cbbd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // cycles to let the three-stage pipeline settle
  localparam int DRAIN_WAIT = 8;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  // pixel [31:0]
  logic [IN_DATA_W-1:0]  s_tdata   = '0;
  logic                  s_tlast   = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  // content_found [0], box_left [12:1], box_top [24:13], box_right [36:25],
  // box_bottom [48:37], too_white [49], zero fill [55:50]
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_wen   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int          pending;
  int          fail_count;
  int          checked;
  int unsigned pixels_sent = 0;
  int unsigned cur_level   = 252000;
  int unsigned gap_pct     = 0;
  int unsigned stall_pct   = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  content_bounds_blank_detect_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wen   (cfg_wen),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  cbbd_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .pending    (pending),
    .fail_count (fail_count),
    .checked    (checked)
  );

  // Receiver: random stall bursts while stall_pct is nonzero
  always begin : result_sink
    @(posedge clk);
    if (stall_pct != 0 && $urandom_range(1, 100) <= stall_pct) begin
      m_tready <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    m_tready <= 1'b1;
  end

  // Mix of white, near-threshold gray and random pixels; top byte always random
  function automatic logic [31:0] pick_pixel(input int unsigned dark_pct);
    logic [31:0] px;
    int unsigned roll;
    int          g;
    px   = $urandom();
    roll = $urandom_range(0, 99);
    if (roll >= dark_pct) begin
      if (roll[0]) begin
        px[23:0] = 24'hFF_FFFF;
      end else begin
        // gray luma is exactly 1000 * g, so this lands within one gray step of the threshold
        g = int'(cur_level / 1000) + int'($urandom_range(0, 2)) - 1;
        if (g < 0) g = 0;
        if (g > 255) g = 255;
        px[23:0] = {3{8'(g)}};
      end
    end
    return px;
  endfunction

  // One pixel transfer, with an optional gap before it
  task automatic send_pixel(input logic [31:0] px, input logic end_img);
    if (gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= px;
    s_tlast  <= end_img;
    do @(posedge clk); while (!s_tready);
    pixels_sent++;
  endtask

  task automatic send_image(input int unsigned n, input int unsigned dark_pct);
    for (int unsigned i = 0; i < n; i++) send_pixel(pick_pixel(dark_pct), i == n - 1);
  endtask

  // Stop sending and wait for every owed summary, then let the pipeline settle
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Write all three registers on back-to-back cycles
  task automatic configure(input int unsigned lw, input int unsigned lvl,
                           input int unsigned ratio);
    cfg_wen   <= 1'b1;
    cfg_index <= REG_LINE_WIDTH;
    cfg_wdata <= CFG_DATA_W'(lw);
    @(posedge clk);
    cfg_index <= REG_WHITE_LEVEL;
    cfg_wdata <= CFG_DATA_W'(lvl);
    @(posedge clk);
    cfg_index <= REG_WHITE_RATIO;
    cfg_wdata <= CFG_DATA_W'(ratio);
    @(posedge clk);
    cfg_wen   <= 1'b0;
    cur_level = lvl;
  endtask

  initial begin : stimulus
    int unsigned p;
    int unsigned phase_start;
    int unsigned n;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Register defaults: all-white image, all-black image
    send_pixel(32'hFFFF_FFFF, 1'b1);
    send_pixel(32'h0000_0000, 1'b1);
    // luma exactly on the level is white, one step under is content
    send_pixel(32'h12FC_FCFC, 1'b0);
    send_pixel(32'h00FB_FBFB, 1'b0);
    send_pixel(32'hFF00_0000, 1'b1);

    // Highest legal level: only full white stays white; full ratio
    drain();
    configure(4, 255000, 10000);
    send_pixel(32'h00FF_FFFF, 1'b0);
    send_pixel(32'hFFFF_FFFE, 1'b0);
    send_pixel(32'h80FF_FFFF, 1'b0);
    send_pixel(32'h00FE_FFFF, 1'b0);
    send_pixel(32'hFFFF_FFFF, 1'b0);
    send_pixel(32'h7FFF_FFFF, 1'b1);

    // Width shrinks mid image below the current column
    drain();
    configure(8, 252000, 5000);
    repeat (6) send_pixel(pick_pixel(50), 1'b0);
    drain();
    configure(4, 252000, 5000);
    send_pixel(pick_pixel(50), 1'b0);
    send_pixel(32'h0000_0000, 1'b0);
    send_pixel(pick_pixel(50), 1'b1);

    // Zero width acts as one; level over range makes everything content
    drain();
    configure(0, 262143, 16383);
    send_image(3, 0);

    // Width over the limit; zero level and zero ratio
    drain();
    configure(8191, 0, 0);
    send_image(2, 50);

    // Random images under a range of settings
    for (p = 0; p < 8; p++) begin
      drain();
      case (p)
        0: configure(0, 0, 0);
        1: configure(1, 262143, 16383);
        2: configure(8191, 255000, 10000);
        3: configure(4096, 252000, 9995);
        default: configure($urandom_range(2, 12),
                           $urandom_range(0, 1) ? 1000 * $urandom_range(0, 255)
                                                : $urandom_range(0, 262143),
                           $urandom_range(0, 10000));
      endcase
      gap_pct   = (p == 2 || p == 7) ? 0 : $urandom_range(5, 40);
      stall_pct = (p == 5 || p == 7) ? 0 : $urandom_range(5, 30);
      phase_start = pixels_sent;
      while (pixels_sent - phase_start < 150) begin
        n = ($urandom_range(0, 6) == 0) ? 1 : $urandom_range(2, 40);
        send_image(n, ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40));
      end
    end

    drain();
    $display("%0d pixels sent, %0d image summaries compared", pixels_sent, checked);
    $display("widths 0 to 8191, levels 0 to 262143, ratios 0 to 16383, with stalls on both sides");
    if (fail_count == 0 && pending == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  initial begin : watchdog
    #4ms;
    $display("simulation failed");
    $finish;
  end

endmodule

### content_bounds_blank_detect_unit.f
src/cbbd_pkg.sv
src/cbbd_accum.sv
src/cbbd_ratio.sv
src/content_bounds_blank_detect_unit.sv
src/cbbd_check.sv
dv/cbbd_checker.sv
dv/tb_content_bounds_blank_detect_unit.sv
